FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PAH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pah check failed");
// next-cycle implication
`define PAH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pah check failed");
`else
`define PAH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PAH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/pah_pkg.sv
// ----------------------------------------------------------------------------
// pah_pkg
// shared types and constants of the piecewise age histogram
// ----------------------------------------------------------------------------
package pah_pkg;

    localparam int MAX_SAMPLES  = 4096;
    localparam int SAMPLE_AW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = SAMPLE_AW + 1;
    localparam int MAX_SECTIONS = 256;
    localparam int SEC_W        = $clog2(MAX_SECTIONS + 1);
    localparam int MAX_BINS     = 64;
    localparam int BIN_AW       = $clog2(MAX_BINS);
    localparam int NB_W         = $clog2(MAX_BINS + 1);

    localparam int VAL_W    = 40;
    localparam int DEP_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int BOUND_W  = DEP_W + SEC_W;
    localparam int COUNT_W  = 13;
    localparam int RNG_W    = 24;
    localparam int WID_W    = 39;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_DEPTH,
        REG_SECTION_THICKNESS,
        REG_QUERY_DEPTH,
        REG_SECTION_COUNT,
        REG_BIN_TOTAL
    } t_cfg_reg;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    row_end;
        logic                    set_end;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0]      bin_count;
        logic [5:0]              bin_index;
        logic signed [RNG_W-1:0] range_low;
        logic signed [RNG_W-1:0] range_high;
        logic [WID_W-1:0]        bin_width;
        logic                    below_base;
        logic                    extrapolated;
        logic                    last_bin;
    } t_out_beat;

    // effective configuration, out-of-range counts already clamped
    typedef struct packed {
        logic [DEP_W-1:0] base;
        logic [DEP_W-1:0] thick;
        logic [DEP_W-1:0] query;
        logic [SEC_W-1:0] nsec;
        logic [NB_W-1:0]  nbins;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_START,
        OP_SLOPE,
        OP_SKIP
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
        logic [DEP_W-1:0]        weight;
        logic                    close;
        logic                    last_row;
    } t_queue_entry;

    typedef struct packed {
        logic                    go;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] minimum;
        logic signed [VAL_W-1:0] maximum;
    } t_set_status;

    typedef struct packed {
        logic                 en;
        logic [SAMPLE_AW-1:0] addr;
        logic [VAL_W-1:0]     data;
    } t_store_wr;

endpackage

FILE: design/piecewise_age_histogram.sv
// ----------------------------------------------------------------------------
// piecewise_age_histogram
// piecewise-linear model value per sample row, binned into a histogram
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_data  (t_in_beat)
//  out       output     o_out_valid / i_out_ready  o_out_data (t_out_beat)
//  cfg       input      i_cfg_wen                  i_cfg_index, i_cfg_wdata
//
//  one row element per cycle through the front, the queue and the
//  three-stage multiply-accumulate; the single accumulator sets that rate
//  but pauses from set end until the binning pass is done
//  at set end: range, then width by restoring divide, all 64 bins cleared,
//  per stored sample a ram read, offset, 6-step divide and counter
//  read-modify-write, then bin beats, each held until taken; input beats
//  keep flowing to the queue during binning; the front stalls only once full
//  synchronous active-low reset; the sample store needs no clearing
//
`include "assert_macros.svh"

module piecewise_age_histogram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pah_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pah_pkg::t_out_beat                o_out_data,
    input  logic                              i_cfg_wen,
    input  logic [pah_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pah_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import pah_pkg::*;

    // configuration registers, raw as written
    logic [DEP_W-1:0] r_base;
    logic [DEP_W-1:0] r_thick;
    logic [DEP_W-1:0] r_query;
    logic [SEC_W-1:0] r_nsec;
    logic [NB_W-1:0]  r_nbins;

    t_cfg         w_cfg;
    logic         w_q_full;
    logic         w_q_empty;
    logic         w_push;
    logic         w_pop;
    logic         w_done;
    t_queue_entry w_entry;
    t_queue_entry w_head;
    t_store_wr    w_store;
    t_set_status  w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_thick <= DEP_W'(1 << FRAC_W);
            r_query <= '0;
            r_nsec  <= SEC_W'(1);
            r_nbins <= NB_W'(10);
        end else if (i_cfg_wen) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_BASE_DEPTH:        r_base  <= i_cfg_wdata;
                REG_SECTION_THICKNESS: r_thick <= i_cfg_wdata;
                REG_QUERY_DEPTH:       r_query <= i_cfg_wdata;
                REG_SECTION_COUNT:     r_nsec  <= i_cfg_wdata[SEC_W-1:0];
                REG_BIN_TOTAL:         r_nbins <= i_cfg_wdata[NB_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts act as one, large counts clamp at the maximum
    always_comb begin
        w_cfg.base  = r_base;
        w_cfg.thick = r_thick;
        w_cfg.query = r_query;
        if (r_nsec == '0) begin
            w_cfg.nsec = SEC_W'(1);
        end else if (r_nsec > SEC_W'(MAX_SECTIONS)) begin
            w_cfg.nsec = SEC_W'(MAX_SECTIONS);
        end else begin
            w_cfg.nsec = r_nsec;
        end
        if (r_nbins == '0) begin
            w_cfg.nbins = NB_W'(1);
        end else if (r_nbins > NB_W'(MAX_BINS)) begin
            w_cfg.nbins = NB_W'(MAX_BINS);
        end else begin
            w_cfg.nbins = r_nbins;
        end
    end

    // front: column tracking and section weights
    pah_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (i_in_data),
        .i_full  (w_q_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    // decoupling queue
    pah_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // back, first half: row accumulation and set statistics
    pah_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_q_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_store  (w_store),
        .o_status (w_status),
        .i_done   (w_done)
    );

    // back, second half: binning pass and count beats
    pah_binner u_binner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_status    (w_status),
        .i_store     (w_store),
        .o_done      (w_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_data)
    );

    // last beat carries the last bin index
    `PAH_ASSERT_IMPLIES(a_last_bin_index, i_clk, i_rst_n, o_out_valid && o_out_data.last_bin, 7'(o_out_data.bin_index) == (w_cfg.nbins - 7'd1))
    // the accumulator holds off while a set is being reported
    `PAH_ASSERT_IMPLIES(a_no_pop_while_out, i_clk, i_rst_n, o_out_valid, !w_pop)
    // once the set is done no beat is left showing
    `PAH_ASSERT_NEXT(a_idle_after_done, i_clk, i_rst_n, w_done, !o_out_valid)

endmodule

FILE: design/pah_ram.sv
// ----------------------------------------------------------------------------
// pah_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pah_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wen,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pah_front.sv
// ----------------------------------------------------------------------------
// pah_front
// takes row elements, tracks the column and works out each section weight
// ----------------------------------------------------------------------------
module pah_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pah_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  pah_pkg::t_in_beat     i_beat,
    input  logic                  i_full,
    output logic                  o_push,
    output pah_pkg::t_queue_entry o_entry
);
    import pah_pkg::*;

    logic [SEC_W-1:0]   r_col, n_col;
    logic [BOUND_W-1:0] r_bound, n_bound;
    logic               accept;
    logic               slope_col;
    logic [DEP_W-1:0]   diff;
    logic [DEP_W-1:0]   weight;

    always_comb begin
        accept    = i_valid && !i_full;
        slope_col = (r_col != '0) && (r_col <= i_cfg.nsec);
        diff      = i_cfg.query - r_bound[DEP_W-1:0];
        // weight clamps to the thickness except in the last section
        if ({{SEC_W{1'b0}}, i_cfg.query} <= r_bound) begin
            weight = '0;
        end else if ((r_col < i_cfg.nsec) && (diff > i_cfg.thick)) begin
            weight = i_cfg.thick;
        end else begin
            weight = diff;
        end

        o_entry.value    = i_beat.value;
        o_entry.weight   = weight;
        o_entry.close    = i_beat.row_end || i_beat.set_end;
        o_entry.last_row = i_beat.set_end;
        if (r_col == '0) begin
            o_entry.op = OP_START;
        end else if (slope_col) begin
            o_entry.op = OP_SLOPE;
        end else begin
            o_entry.op = OP_SKIP;
        end

        n_col   = r_col;
        n_bound = r_bound;
        if (accept) begin
            if (r_col == '0) begin
                n_bound = {{SEC_W{1'b0}}, i_cfg.base};
            end else if (slope_col) begin
                n_bound = r_bound + {{SEC_W{1'b0}}, i_cfg.thick};
            end
            if (i_beat.row_end || i_beat.set_end) begin
                n_col = '0;
            end else if (r_col <= i_cfg.nsec) begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_bound <= '0;
        end else begin
            r_col   <= n_col;
            r_bound <= n_bound;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = accept;

endmodule

FILE: design/pah_queue.sv
// ----------------------------------------------------------------------------
// pah_queue
// short queue between the classifying front and the accumulating back
// ----------------------------------------------------------------------------
module pah_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pah_pkg::t_queue_entry i_entry,
    input  logic                  i_pop,
    output pah_pkg::t_queue_entry o_head,
    output logic                  o_full,
    output logic                  o_empty
);
    import pah_pkg::*;

    t_queue_entry        r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: design/pah_mac.sv
// ----------------------------------------------------------------------------
// pah_mac
// slope times weight accumulation per row, sample store writes, min and max
// ----------------------------------------------------------------------------
module pah_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  pah_pkg::t_queue_entry i_head,
    output logic                  o_pop,
    output pah_pkg::t_store_wr    o_store,
    output pah_pkg::t_set_status  o_status,
    input  logic                  i_done
);
    import pah_pkg::*;

    localparam int PROD_W = VAL_W + FRAC_W + 1;

    typedef enum logic [1:0] {
        S_RUN,
        S_DRAIN,
        S_LAUNCH,
        S_WAIT
    } t_state;

    t_state                   r_state;
    logic                     r_a_valid;
    t_op                      r_a_op;
    logic signed [VAL_W-1:0]  r_a_value;
    logic                     r_a_close;
    logic                     r_a_last;
    logic signed [PROD_W-1:0] r_a_hi;
    logic signed [PROD_W-1:0] r_a_lo;
    logic                     r_b_valid;
    logic                     r_b_close;
    logic                     r_b_last;
    logic signed [VAL_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_count;
    logic signed [VAL_W-1:0]  r_min;
    logic signed [VAL_W-1:0]  r_max;

    logic                     pop;
    logic signed [PROD_W-1:0] hi_prod;
    logic signed [PROD_W-1:0] lo_prod;
    logic signed [PROD_W-1:0] term;
    logic signed [PROD_W:0]   sum;
    logic signed [VAL_W-1:0]  sat_sum;
    logic                     store_full;
    logic                     keep;

    always_comb begin
        pop     = (r_state == S_RUN) && !i_empty;
        hi_prod = $signed(i_head.value) * $signed({1'b0, i_head.weight[DEP_W-1:FRAC_W]});
        lo_prod = $signed(i_head.value) * $signed({1'b0, i_head.weight[FRAC_W-1:0]});
        // floor of the full product is the high part plus the floored low part
        term    = r_a_hi + (r_a_lo >>> FRAC_W);
        sum     = (PROD_W + 1)'(r_acc) + (PROD_W + 1)'(term);
        if (sum > (PROD_W + 1)'(Q_MAX)) begin
            sat_sum = Q_MAX;
        end else if (sum < (PROD_W + 1)'(Q_MIN)) begin
            sat_sum = Q_MIN;
        end else begin
            sat_sum = sum[VAL_W-1:0];
        end
        store_full = (r_count == CNT_W'(MAX_SAMPLES));
        keep       = r_b_valid && r_b_close && !store_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_count   <= '0;
            r_min     <= Q_MAX;
            r_max     <= Q_MIN;
            r_acc     <= '0;
        end else begin
            // stage a: products
            r_a_valid <= pop;
            r_a_op    <= i_head.op;
            r_a_value <= i_head.value;
            r_a_close <= i_head.close;
            r_a_last  <= i_head.last_row;
            r_a_hi    <= hi_prod;
            r_a_lo    <= lo_prod;

            // stage b: accumulate
            r_b_valid <= r_a_valid;
            r_b_close <= r_a_close;
            r_b_last  <= r_a_last;
            if (r_a_valid) begin
                unique case (r_a_op)
                    OP_START: r_acc <= r_a_value;
                    OP_SLOPE: r_acc <= sat_sum;
                    default:  r_acc <= r_acc;
                endcase
            end

            // stage c: row close
            if (keep) begin
                r_count <= r_count + 1'b1;
                if (r_acc < r_min) begin
                    r_min <= r_acc;
                end
                if (r_acc > r_max) begin
                    r_max <= r_acc;
                end
            end

            unique case (r_state)
                S_RUN: begin
                    if (pop && i_head.last_row) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_b_valid && r_b_last) begin
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_done) begin
                        r_state <= S_RUN;
                        r_count <= '0;
                        r_min   <= Q_MAX;
                        r_max   <= Q_MIN;
                        r_acc   <= '0;
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    always_comb begin
        o_pop            = pop;
        o_store.en       = keep;
        o_store.addr     = r_count[SAMPLE_AW-1:0];
        o_store.data     = r_acc;
        o_status.go      = (r_state == S_LAUNCH);
        o_status.count   = r_count;
        o_status.minimum = r_min;
        o_status.maximum = r_max;
    end

endmodule

FILE: design/pah_binner.sv
// ----------------------------------------------------------------------------
// pah_binner
// range, bin width, binning pass over the stored samples and count readout
// ----------------------------------------------------------------------------
module pah_binner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pah_pkg::t_cfg        i_cfg,
    input  pah_pkg::t_set_status i_status,
    input  pah_pkg::t_store_wr   i_store,
    output logic                 o_done,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pah_pkg::t_out_beat   o_out_beat
);
    import pah_pkg::*;

    localparam int NUM_W = RNG_W + FRAC_W;      // scaled range
    localparam int PN_W  = NUM_W + NB_W;        // offset times bin total
    localparam int DEN_W = NUM_W + BIN_AW - 1;  // scaled range, top divisor step

    typedef enum logic [3:0] {
        B_IDLE,
        B_RANGE,
        B_WDIV,
        B_WSAT,
        B_CLR,
        B_SRD,
        B_SOFF,
        B_SMUL,
        B_SDIV,
        B_CRD,
        B_CWR,
        B_ERD,
        B_ELD,
        B_EWAIT
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic signed [RNG_W-1:0] r_lo;
    logic signed [RNG_W-1:0] r_hi;
    logic [RNG_W-1:0]        r_range;
    logic [NUM_W-1:0]        r_num;
    logic [NB_W-1:0]         r_rem;
    logic [5:0]              r_step;
    logic [WID_W-1:0]        r_width;
    logic [NB_W-1:0]         r_bin;
    logic [CNT_W-1:0]        r_i;
    logic [NUM_W-1:0]        r_off;
    logic [PN_W-1:0]         r_pn;
    logic [DEN_W-1:0]        r_den;
    logic [BIN_AW-1:0]       r_q;
    logic [BIN_AW-1:0]       r_j;
    logic [BIN_AW-1:0]       r_r;
    logic [BOUND_W-1:0]      r_span;
    logic                    r_extra;
    logic                    r_below;
    logic                    r_done;
    logic                    r_out_valid;
    t_out_beat               r_out;

    logic [VAL_W-1:0]        store_rdata;
    logic [COUNT_W-1:0]      bin_rdata;
    logic                    bin_wen;
    logic [BIN_AW-1:0]       bin_waddr;
    logic [COUNT_W-1:0]      bin_wdata;
    logic [BIN_AW-1:0]       bin_raddr;

    logic signed [VAL_W-1:0] lo_full;
    logic signed [VAL_W:0]   hi_sum;
    logic signed [VAL_W:0]   hi_full;
    logic signed [RNG_W:0]   diff;
    logic [NB_W:0]           wshift;
    logic                    wge;
    logic [NB_W:0]           wsub;
    logic [NUM_W-1:0]        scaled;
    logic signed [VAL_W:0]   off;
    logic                    sge;
    logic [BIN_AW-1:0]       last_idx;

    pah_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_wen   (i_store.en),
        .i_waddr (i_store.addr),
        .i_wdata (i_store.data),
        .i_raddr (r_i[SAMPLE_AW-1:0]),
        .o_rdata (store_rdata)
    );

    pah_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_BINS)) u_bins (
        .i_clk   (i_clk),
        .i_wen   (bin_wen),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rdata)
    );

    always_comb begin
        lo_full  = i_status.minimum >>> FRAC_W;
        hi_sum   = (VAL_W + 1)'(i_status.maximum) + (VAL_W + 1)'((1 << FRAC_W) - 1);
        hi_full  = hi_sum >>> FRAC_W;
        diff     = (RNG_W + 1)'(r_hi) - (RNG_W + 1)'(r_lo);
        wshift   = {r_rem, r_num[NUM_W-1]};
        wge      = wshift >= {1'b0, i_cfg.nbins};
        wsub     = wshift - {1'b0, i_cfg.nbins};
        scaled   = {r_range, {FRAC_W{1'b0}}};
        off      = (VAL_W + 1)'($signed(store_rdata))
                 - $signed({r_lo[RNG_W-1], r_lo, {FRAC_W{1'b0}}});
        sge      = r_pn >= PN_W'(r_den);
        last_idx = BIN_AW'(i_cfg.nbins - 1'b1);

        bin_wen   = 1'b0;
        bin_waddr = r_j;
        bin_wdata = '0;
        if (r_state == B_CLR) begin
            bin_wen   = 1'b1;
            bin_waddr = r_bin[BIN_AW-1:0];
        end else if (r_state == B_CWR) begin
            bin_wen   = 1'b1;
            bin_wdata = (bin_rdata == '1) ? bin_rdata : bin_rdata + 1'b1;
        end
        bin_raddr = (r_state == B_ERD) ? r_r : r_j;
    end

    // section span and depth flags follow the configuration
    always_ff @(posedge i_clk) begin
        r_span  <= BOUND_W'(i_cfg.nsec) * BOUND_W'(i_cfg.thick);
        r_extra <= {1'b0, {SEC_W{1'b0}}, i_cfg.query}
                   >= ({1'b0, {SEC_W{1'b0}}, i_cfg.base} + {1'b0, r_span});
        r_below <= i_cfg.query < i_cfg.base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_status.go) begin
                        r_count <= i_status.count;
                        if (i_status.count == '0) begin
                            r_lo <= '0;
                            r_hi <= '0;
                        end else begin
                            r_lo <= lo_full[RNG_W-1:0];
                            // ceiling saturates at the top of the integer range
                            if (hi_full > (VAL_W + 1)'(Q_MAX >>> FRAC_W)) begin
                                r_hi <= {1'b0, {(RNG_W-1){1'b1}}};
                            end else begin
                                r_hi <= hi_full[RNG_W-1:0];
                            end
                        end
                        r_state <= B_RANGE;
                    end
                end
                B_RANGE: begin
                    r_range <= diff[RNG_W-1:0];
                    r_num   <= {diff[RNG_W-1:0], {FRAC_W{1'b0}}};
                    r_rem   <= '0;
                    r_step  <= 6'(NUM_W - 1);
                    r_state <= B_WDIV;
                end
                B_WDIV: begin
                    // restoring division of the scaled range by the bin total
                    r_rem <= wge ? wsub[NB_W-1:0] : wshift[NB_W-1:0];
                    r_num <= {r_num[NUM_W-2:0], wge};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= B_WSAT;
                    end
                end
                B_WSAT: begin
                    r_width <= r_num[NUM_W-1] ? '1 : r_num[WID_W-1:0];
                    r_bin   <= '0;
                    r_state <= B_CLR;
                end
                B_CLR: begin
                    r_bin <= r_bin + 1'b1;
                    if (r_bin == NB_W'(MAX_BINS - 1)) begin
                        r_i     <= '0;
                        r_r     <= '0;
                        r_state <= (r_count == '0) ? B_ERD : B_SRD;
                    end
                end
                B_SRD: begin
                    r_state <= B_SOFF;
                end
                B_SOFF: begin
                    r_off   <= off[VAL_W] ? '0 : off[NUM_W-1:0];
                    r_state <= B_SMUL;
                end
                B_SMUL: begin
                    if (r_range == '0) begin
                        r_j     <= '0;
                        r_state <= B_CRD;
                    end else if (r_off >= scaled) begin
                        // at or beyond the top goes to the last bin
                        r_j     <= last_idx;
                        r_state <= B_CRD;
                    end else begin
                        r_pn    <= PN_W'(r_off) * PN_W'(i_cfg.nbins);
                        r_den   <= {scaled, {(BIN_AW-1){1'b0}}};
                        r_q     <= '0;
                        r_step  <= 6'(BIN_AW - 1);
                        r_state <= B_SDIV;
                    end
                end
                B_SDIV: begin
                    if (sge) begin
                        r_pn <= r_pn - PN_W'(r_den);
                    end
                    r_q   <= {r_q[BIN_AW-2:0], sge};
                    r_den <= r_den >> 1;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_j     <= {r_q[BIN_AW-2:0], sge};
                        r_state <= B_CRD;
                    end
                end
                B_CRD: begin
                    r_state <= B_CWR;
                end
                B_CWR: begin
                    r_i <= r_i + 1'b1;
                    if (CNT_W'(r_i + 1'b1) == r_count) begin
                        r_r     <= '0;
                        r_state <= B_ERD;
                    end else begin
                        r_state <= B_SRD;
                    end
                end
                B_ERD: begin
                    r_state <= B_ELD;
                end
                B_ELD: begin
                    r_out.bin_count    <= bin_rdata;
                    r_out.bin_index    <= 6'(r_r);
                    r_out.range_low    <= r_lo;
                    r_out.range_high   <= r_hi;
                    r_out.bin_width    <= r_width;
                    r_out.below_base   <= r_below;
                    r_out.extrapolated <= r_extra;
                    r_out.last_bin     <= (r_r == last_idx);
                    r_out_valid        <= 1'b1;
                    r_state            <= B_EWAIT;
                end
                B_EWAIT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last_bin) begin
                            r_done  <= 1'b1;
                            r_state <= B_IDLE;
                        end else begin
                            r_r     <= r_r + 1'b1;
                            r_state <= B_ERD;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
